[rtl/core/brbo_pkg.sv]
// Package for the byte ring buffer: command and status codes, field widths,
// and the job descriptor passed from the front end to the back end.
// No dependencies.
`default_nettype none

package brbo_pkg;

	// Field widths of the request and result channels
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;
	localparam int FILL_W = 8;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [FILL_W-1:0] FILL_SAT = 8'd255;

	// Entries of the job queue between front and back end
	localparam int JQ_DEPTH = 4;
	// Counter of runs in flight: queued jobs plus the one in the back end
	localparam int RUNS_W   = $clog2(JQ_DEPTH + 2);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	// Everything the back end needs for one command except the start address
	typedef struct packed {
		logic                is_run;
		status_t             status;
		logic [CNT_W-1:0]    done;
		logic [FILL_W-1:0]   fill;
	} job_info_t;

endpackage

`default_nettype wire

[rtl/core/brbo_ifs.sv]
// Channel interfaces of the byte ring buffer: command requests in, results out.
// Depends on brbo_pkg.
`default_nettype none

interface brbo_cmd_if;
	import brbo_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;
	logic [CNT_W-1:0]  count;

	modport source (output valid, output command, output data_byte, output count, input ready);
	modport sink   (input valid, input command, input data_byte, input count, output ready);
endinterface

interface brbo_res_if;
	import brbo_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  done_count;
	logic [FILL_W-1:0] fill_level;
	logic              last;

	modport source (output valid, output out_byte, output status, output done_count,
		output fill_level, output last, input ready);
	modport sink   (input valid, input out_byte, input status, input done_count,
		input fill_level, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/brbo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brbo_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

[rtl/core/brbo_front.sv]
// Front end: accepts command requests, owns the read and write pointers,
// writes appended bytes, and queues one job descriptor per command.
// Depends on brbo_pkg and brbo_ifs.
`default_nettype none

module brbo_front #(
	parameter int DEPTH   = 256,
	parameter int MAX_RUN = 64,
	parameter int AW      = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	brbo_cmd_if.sink                         cmd_ch,
	// job queue write side
	output logic                             q_push,
	output brbo_pkg::job_info_t              q_info,
	output logic [AW-1:0]                    q_start,
	input  wire logic                        q_full,
	// back end finished the final byte of a run
	input  wire logic                        run_done,
	// byte store write port
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic [brbo_pkg::BYTE_W-1:0]      mem_wdata
);
	import brbo_pkg::*;

	localparam int CW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [CW-1:0] MAXRUN_C = CW'(MAX_RUN);

	logic [AW-1:0]     rp_q, wp_q;
	logic [RUNS_W-1:0] runs_q;

	cmd_t        cmd;
	logic [CW-1:0] rp_w, wp_w, level, want, n, wp_inc, rp_inc, rp_adv, fill_after;
	logic [CW-1:0] rp_nx, wp_nx;
	logic        short_run, drop, accept;
	job_info_t   info;

	// Classify the request and work out the pointer updates
	always_comb begin
		cmd  = cmd_t'(cmd_ch.command);
		rp_w = CW'(rp_q);
		wp_w = CW'(wp_q);
		level = (wp_w >= rp_w) ? (wp_w - rp_w) : (wp_w + DEPTH_C - rp_w);

		want = CW'(cmd_ch.count);
		if (want > MAXRUN_C) begin
			want = MAXRUN_C;
		end
		n         = want;
		short_run = 1'b0;
		if (level < want) begin
			n         = level;
			short_run = 1'b1;
		end

		wp_inc = wp_w + CW'(1);
		if (wp_inc >= DEPTH_C) begin
			wp_inc = '0;
		end
		rp_inc = rp_w + CW'(1);
		if (rp_inc >= DEPTH_C) begin
			rp_inc = '0;
		end
		rp_adv = rp_w + n;
		if (rp_adv >= DEPTH_C) begin
			rp_adv = rp_adv - DEPTH_C;
		end
		drop = (wp_inc == rp_w);

		rp_nx       = rp_w;
		wp_nx       = wp_w;
		fill_after  = level;
		info.is_run = 1'b0;
		info.status = short_run ? ST_SHORT : ST_OK;
		info.done   = CNT_W'(n);
		case (cmd)
			CMD_APPEND: begin
				wp_nx       = wp_inc;
				rp_nx       = drop ? rp_inc : rp_w;
				fill_after  = drop ? level : level + CW'(1);
				info.status = drop ? ST_FULL : ST_OK;
				info.done   = CNT_W'(1);
			end
			CMD_POP: begin
				rp_nx       = rp_adv;
				fill_after  = level - n;
				info.is_run = (n != '0);
			end
			CMD_PEEK: begin
				info.is_run = (n != '0);
			end
			CMD_REMOVE: begin
				rp_nx      = rp_adv;
				fill_after = level - n;
			end
			default: begin
				rp_nx = rp_w;
			end
		endcase
		info.fill = (fill_after > CW'(FILL_SAT)) ? FILL_SAT : FILL_W'(fill_after);
	end

	// An append waits while a run still has to read the store
	assign cmd_ch.ready = !q_full && !((cmd == CMD_APPEND) && (runs_q != '0));
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	assign q_push  = accept;
	assign q_info  = info;
	assign q_start = rp_q;

	assign mem_we    = accept && (cmd == CMD_APPEND);
	assign mem_waddr = wp_q;
	assign mem_wdata = cmd_ch.data_byte;

	// Pointers and the count of runs in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			runs_q <= '0;
		end else begin
			if (accept) begin
				rp_q <= AW'(rp_nx);
				wp_q <= AW'(wp_nx);
			end
			case ({accept && info.is_run, run_done})
				2'b10:   runs_q <= runs_q + RUNS_W'(1);
				2'b01:   runs_q <= runs_q - RUNS_W'(1);
				default: runs_q <= runs_q;
			endcase
		end
	end

	a_run_done_counted: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |-> runs_q != '0)
		else $error("run finished with no run counted");

	a_append_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_APPEND) |=> wp_q != rp_q)
		else $error("buffer empty after append");
endmodule

`default_nettype wire

[rtl/core/brbo_jobq.sv]
// Job queue: a short flip-flop FIFO of job descriptors between front and back end.
// Depends on brbo_pkg.
`default_nettype none

module brbo_jobq #(
	parameter int W       = 8,
	parameter int ENTRIES = brbo_pkg::JQ_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);
	localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW = $clog2(ENTRIES + 1);

	logic [W-1:0]  slot_q [ENTRIES];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] num_q;

	assign full     = (num_q == NW'(ENTRIES));
	assign empty    = (num_q == '0);
	assign pop_data = slot_q[rd_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(ENTRIES - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(ENTRIES - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   num_q <= num_q + NW'(1);
				2'b01:   num_q <= num_q - NW'(1);
				default: num_q <= num_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && push |-> pop)
		else $error("job queue overflow");
endmodule

`default_nettype wire

[rtl/core/brbo_back.sv]
// Back end: takes queued jobs, reads run bytes off the store one per cycle while
// the output is free; drives the registered result channel. Uses brbo_pkg, brbo_ifs.
`default_nettype none

module brbo_back #(
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// job queue read side
	input  wire logic                    q_empty,
	input  wire brbo_pkg::job_info_t     q_info,
	input  wire logic [AW-1:0]           q_start,
	output logic                         q_pop,
	// byte store read port
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  wire logic [brbo_pkg::BYTE_W-1:0] mem_rdata,
	output logic                         run_done,
	brbo_res_if.source                   res_ch
);
	import brbo_pkg::*;

	// current job
	logic             act_q;
	job_info_t        info_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] left_q;
	// byte in the RAM read register, not yet moved to the output
	logic             pend_q, pend_last_q;
	// result register
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	status_t           out_status_q;
	logic [CNT_W-1:0]  out_done_q;
	logic [FILL_W-1:0] out_fill_q;
	logic              out_last_q;

	logic          out_free, move, issue, single_go, finish;
	logic [AW-1:0] addr_inc;

	always_comb begin
		out_free  = !out_v_q || res_ch.ready;
		move      = pend_q && out_free;
		issue     = act_q && info_q.is_run && (left_q != '0) && (!pend_q || move);
		single_go = act_q && !info_q.is_run && out_free;
		run_done  = move && pend_last_q;
		finish    = single_go || run_done;
		q_pop     = !q_empty && (!act_q || finish);
		addr_inc  = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);
	end

	assign mem_re    = issue;
	assign mem_raddr = addr_q;

	// Job and read control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			info_q      <= '0;
			addr_q      <= '0;
			left_q      <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (issue) begin
				addr_q      <= addr_inc;
				left_q      <= left_q - CNT_W'(1);
				pend_last_q <= (left_q == CNT_W'(1));
			end
			if (q_pop) begin
				act_q  <= 1'b1;
				info_q <= q_info;
				addr_q <= q_start;
				left_q <= q_info.done;
			end else if (finish) begin
				act_q <= 1'b0;
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move || single_go) begin
			out_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= mem_rdata;
			out_last_q <= pend_last_q;
		end else if (single_go) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
		end
		if (move || single_go) begin
			out_status_q <= info_q.status;
			out_done_q   <= info_q.done;
			out_fill_q   <= info_q.fill;
		end
	end

	assign res_ch.valid      = out_v_q;
	assign res_ch.out_byte   = out_byte_q;
	assign res_ch.status     = out_status_q;
	assign res_ch.done_count = out_done_q;
	assign res_ch.fill_level = out_fill_q;
	assign res_ch.last       = out_last_q;

	a_pend_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> act_q && info_q.is_run)
		else $error("read in flight outside a run");

	a_run_progress: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && info_q.is_run |-> (left_q != '0) || pend_q)
		else $error("run stalled with nothing left to read");
endmodule

`default_nettype wire

[rtl/core/byte_ring_buffer_overwrite_top.sv]
// Top level of the byte ring buffer with drop-oldest on overflow.
// Depends on brbo_pkg, brbo_ifs, brbo_ram, brbo_front, brbo_jobq, brbo_back.
//
//   Port    Dir  Fields                                          Role
//   cmd_ch  in   command, data_byte, count                       command requests
//   res_ch  out  out_byte, status, done_count, fill_level, last  results, one per byte or command
//
// Append, remove, empty pop/peek: one request per cycle unless stalled, one result each.
// Pop/peek runs: one byte per cycle off the store's single read port unless stalled;
// the first byte passes the job, RAM read and result registers.
// An append waits while a pop or peek run is queued or still being read.
// Reset clears the pointers and the queue at once; the store is not cleared.
// Either side may stall; a four-entry job queue and the result register decouple them.
`default_nettype none

module byte_ring_buffer_overwrite_top #(
	parameter int DEPTH   = 256,
	parameter int MAX_RUN = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	brbo_cmd_if.sink   cmd_ch,
	brbo_res_if.source res_ch
);
	import brbo_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int QW = $bits(job_info_t) + AW;

	logic              q_push, q_full, q_pop, q_empty, run_done;
	job_info_t         push_info, pop_info;
	logic [AW-1:0]     push_start, pop_start;
	logic [QW-1:0]     pop_word;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;

	brbo_front #(.DEPTH(DEPTH), .MAX_RUN(MAX_RUN), .AW(AW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.q_push    (q_push),
		.q_info    (push_info),
		.q_start   (push_start),
		.q_full    (q_full),
		.run_done  (run_done),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	brbo_jobq #(.W(QW), .ENTRIES(JQ_DEPTH)) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_info, push_start}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_word),
		.empty     (q_empty)
	);

	assign pop_info  = job_info_t'(pop_word[QW-1:AW]);
	assign pop_start = pop_word[AW-1:0];

	brbo_ram #(.W(BYTE_W), .D(DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	brbo_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_info    (pop_info),
		.q_start   (pop_start),
		.q_pop     (q_pop),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.run_done  (run_done),
		.res_ch    (res_ch)
	);
endmodule

`default_nettype wire

[verif/byte_ring_buffer_overwrite_top_tb.sv]
// Testbench for byte_ring_buffer_overwrite_top: drives command requests and
// checks every result against a cycle-free ring buffer predictor.
// Depends on brbo_pkg, brbo_ifs and the RTL under rtl/core.
`timescale 1ns / 100ps

module byte_ring_buffer_overwrite_top_tb;
	import brbo_pkg::*;

	localparam int RING_DEPTH  = 256;
	localparam int RUN_MAX     = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;

	// One predicted result of a command
	typedef struct {
		logic [BYTE_W-1:0] data;
		status_t           st;
		logic [CNT_W-1:0]  done;
		logic [FILL_W-1:0] fill;
		logic              last;
	} ring_result_t;

	logic clk;
	logic arst_n;

	brbo_cmd_if cmd_ch ();
	brbo_res_if res_ch ();

	byte_ring_buffer_overwrite_top #(
		.DEPTH   (RING_DEPTH),
		.MAX_RUN (RUN_MAX)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	// Predictor state
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	int                rd_ptr;
	int                wr_ptr;
	ring_result_t      pending_results [$];

	int snd_idle_pct;
	int rcv_idle_pct;
	int mismatch_cnt;
	int cycle_cnt;

	// Clock: 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bytes held, as the block reports it
	function automatic int ring_level();
		return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
	endfunction

	function automatic void push_result(logic [BYTE_W-1:0] data, status_t st, int done,
		logic last);
		ring_result_t r;
		int lvl;
		lvl    = ring_level();
		r.data = data;
		r.st   = st;
		r.done = done[CNT_W-1:0];
		r.fill = (lvl > 255) ? FILL_SAT : lvl[FILL_W-1:0];
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// Apply one accepted request to the predictor and queue its results
	function automatic void predict_request(cmd_t c, logic [BYTE_W-1:0] d,
		logic [CNT_W-1:0] n);
		int want;
		int take;
		int start;
		status_t st;
		st = ST_OK;
		if (c == CMD_APPEND) begin
			ring_mem[wr_ptr] = d;
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			// overflow: oldest byte is dropped
			if (wr_ptr == rd_ptr) begin
				rd_ptr = (rd_ptr + 1) % RING_DEPTH;
				st = ST_FULL;
			end
			push_result('0, st, 1, 1'b1);
			return;
		end
		want = (int'(n) > RUN_MAX) ? RUN_MAX : int'(n);
		take = want;
		if (ring_level() < take) begin
			take = ring_level();
			st = ST_SHORT;
		end
		if (c == CMD_REMOVE) begin
			rd_ptr = (rd_ptr + take) % RING_DEPTH;
			push_result('0, st, take, 1'b1);
		end else if (take == 0) begin
			push_result('0, st, 0, 1'b1);
		end else begin
			start = rd_ptr;
			if (c == CMD_POP)
				rd_ptr = (rd_ptr + take) % RING_DEPTH;
			for (int i = 0; i < take; i++)
				push_result(ring_mem[(start + i) % RING_DEPTH], st, take, i == take - 1);
		end
	endfunction

	// Send one request; entered and left at a falling edge, valid left high
	task automatic send_request(cmd_t c, logic [BYTE_W-1:0] d, logic [CNT_W-1:0] n);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     = 1'b1;
		cmd_ch.command   = c;
		cmd_ch.data_byte = d;
		cmd_ch.count     = n;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_request(c, d, n);
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic drain_results();
		cmd_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [CNT_W-1:0] rand_count();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return CNT_W'($urandom_range(3));
		else if (r < 30)
			return CNT_W'($urandom_range(127));
		return CNT_W'($urandom_range(70));
	endfunction

	// Empty-buffer runs, field extremes, clipping and saturation of count
	task automatic test_directed();
		send_request(CMD_POP, 8'h00, 7'd5);
		send_request(CMD_PEEK, 8'h00, 7'd0);
		send_request(CMD_REMOVE, 8'hFF, 7'd3);
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_APPEND, 8'h00, 7'd0);
		send_request(CMD_APPEND, 8'hFF, 7'd127);
		send_request(CMD_APPEND, 8'hA5, 7'd0);
		send_request(CMD_APPEND, 8'h5A, 7'd64);
		send_request(CMD_PEEK, 8'h00, 7'd2);
		send_request(CMD_PEEK, 8'h00, 7'd0);
		send_request(CMD_POP, 8'h00, 7'd127);
		for (int i = 0; i < 6; i++)
			send_request(CMD_APPEND, 8'(8'h11 * (i + 1)), 7'd0);
		send_request(CMD_REMOVE, 8'h00, 7'd2);
		send_request(CMD_PEEK, 8'h00, 7'd64);
		send_request(CMD_POP, 8'h00, 7'd3);
		send_request(CMD_REMOVE, 8'h00, 7'd127);
		send_request(CMD_APPEND, 8'h3C, 7'd0);
		send_request(CMD_POP, 8'h00, 7'd1);
	endtask

	// Fill past capacity so the oldest bytes are dropped, then drain in long runs
	task automatic test_overflow();
		for (int i = 0; i < 262; i++) begin
			send_request(CMD_APPEND, 8'($urandom_range(255)), 7'($urandom_range(127)));
			if (i == 256)
				send_request(CMD_PEEK, 8'h00, 7'd64);
		end
		send_request(CMD_POP, 8'h00, 7'd64);
		send_request(CMD_POP, 8'h00, 7'd100);
		send_request(CMD_PEEK, 8'h00, 7'd70);
		send_request(CMD_REMOVE, 8'h00, 7'd64);
		send_request(CMD_POP, 8'h00, 7'd64);
		send_request(CMD_POP, 8'h00, 7'd1);
	endtask

	// Bursts of appends followed by runs, with stray commands mixed in
	task automatic test_random(int n_req);
		int sent;
		int burst;
		int r;
		sent = 0;
		while (sent < n_req) begin
			r = $urandom_range(99);
			if (r < 55) begin
				burst = $urandom_range(1, 24);
				for (int i = 0; i < burst; i++)
					send_request(CMD_APPEND, 8'($urandom_range(255)), rand_count());
				sent += burst;
			end else begin
				r = $urandom_range(2);
				if (r == 0)
					send_request(CMD_POP, 8'($urandom_range(255)), rand_count());
				else if (r == 1)
					send_request(CMD_PEEK, 8'($urandom_range(255)), rand_count());
				else
					send_request(CMD_REMOVE, 8'($urandom_range(255)), rand_count());
				sent++;
			end
		end
	endtask

	// Result receiver: ready changes on the falling edge
	always @(negedge clk) begin
		if (arst_n)
			res_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin : check_results
		ring_result_t want_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_cnt < REPORT_MAX)
					$display("%0t: unexpected result byte=%0h status=%0d done=%0d fill=%0d last=%0b",
						$realtime, res_ch.out_byte, res_ch.status, res_ch.done_count,
						res_ch.fill_level, res_ch.last);
				mismatch_cnt++;
			end else begin
				want_r = pending_results.pop_front();
				if (res_ch.out_byte !== want_r.data || res_ch.status !== want_r.st ||
					res_ch.done_count !== want_r.done || res_ch.fill_level !== want_r.fill ||
					res_ch.last !== want_r.last) begin
					if (mismatch_cnt < REPORT_MAX) begin
						$display("%0t: result mismatch", $realtime);
						$display("  byte   exp %0h got %0h", want_r.data, res_ch.out_byte);
						$display("  status exp %0d got %0d", want_r.st, res_ch.status);
						$display("  done   exp %0d got %0d", want_r.done, res_ch.done_count);
						$display("  fill   exp %0d got %0d", want_r.fill, res_ch.fill_level);
						$display("  last   exp %0b got %0b", want_r.last, res_ch.last);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("byte_ring_buffer_overwrite_top_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.command   = CMD_APPEND;
		cmd_ch.data_byte = '0;
		cmd_ch.count     = '0;
		res_ch.ready     = 1'b0;
		rd_ptr           = 0;
		wr_ptr           = 0;
		mismatch_cnt     = 0;
		cycle_cnt        = 0;
		snd_idle_pct     = 7;
		rcv_idle_pct     = 56;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender mostly busy, receiver stalls often
		test_directed();
		test_overflow();
		drain_results();

		// sender idles often, receiver mostly ready
		snd_idle_pct = 56;
		rcv_idle_pct = 7;
		test_random(85);
		drain_results();

		// no idling on either side
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(85);
		drain_results();
		repeat (20) @(negedge clk);

		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("byte_ring_buffer_overwrite_top_tb: clean");
		else
			$display("byte_ring_buffer_overwrite_top_tb: errors");
		$finish;
	end

endmodule
